@@ hdl/kstr_pkg.sv @@
// ----------------------------------------------------------------------------
// kstr_pkg
// Shared types and constants of the six-key rollover report tracker: the
// input and report beat layouts, the usage-code lookup bundle and status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package kstr_pkg;

	// Scan codes index a 128-entry translation table.
	localparam int SCAN_W      = 7;
	localparam int TABLE_DEPTH = 1 << SCAN_W;

	// Number of slots tracked by default, and slots carried in a report.
	localparam int KEY_SLOTS_DEF = 6;
	localparam int REPORT_SLOTS  = 6;

	// Upper five bits shared by the modifier usages 0xE0 through 0xE7.
	localparam logic [4:0] MOD_PREFIX = 5'b11100;

	typedef logic [7:0] usage_t;

	typedef enum logic {
		OP_KEY   = 1'b0,
		OP_TABLE = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_IGNORED    = 3'd1,
		ST_NOT_LISTED = 3'd2,
		ST_DUPLICATE  = 3'd3,
		ST_FULL       = 3'd4
	} status_t;

	typedef struct packed {
		logic              operation;
		logic [7:0]        raw_key;
		logic [SCAN_W-1:0] table_index;
		logic [7:0]        table_value;
	} evt_t;

	typedef struct packed {
		logic [7:0] modifier_bits;
		logic [7:0] slot_zero;
		logic [7:0] slot_one;
		logic [7:0] slot_two;
		logic [7:0] slot_three;
		logic [7:0] slot_four;
		logic [7:0] slot_five;
		logic [2:0] status;
	} rpt_t;

	// Translated key event as seen by the update logic.
	typedef struct packed {
		usage_t code;
		logic   is_release;
	} lookup_t;

endpackage

`default_nettype wire

@@ hdl/kstr_table.sv @@
// ----------------------------------------------------------------------------
// kstr_table
// Scan-code to usage-code translation memory with per-entry valid bits and a
// registered read port that feeds the update stage.
// ----------------------------------------------------------------------------
`default_nettype none

module kstr_table (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        load,
	input  wire logic                        wr_en,
	input  wire logic [kstr_pkg::SCAN_W-1:0] wr_index,
	input  wire kstr_pkg::usage_t            wr_value,
	input  wire logic [7:0]                  raw_key,
	output kstr_pkg::lookup_t                look
);

	kstr_pkg::usage_t                    mem [kstr_pkg::TABLE_DEPTH];
	logic [kstr_pkg::TABLE_DEPTH-1:0]    valid_q;
	kstr_pkg::usage_t                    rd_data_s1;
	logic                                rd_valid_s1;
	logic                                is_release_s1;

	// Storage and read data: no reset, an unwritten entry is masked below.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_index] <= wr_value;
		end
		if (load) begin
			rd_data_s1 <= mem[raw_key[kstr_pkg::SCAN_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q       <= '0;
			rd_valid_s1   <= 1'b0;
			is_release_s1 <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_index] <= 1'b1;
			end
			if (load) begin
				rd_valid_s1   <= valid_q[raw_key[kstr_pkg::SCAN_W-1:0]];
				is_release_s1 <= raw_key[7];
			end
		end
	end

	assign look.code       = rd_valid_s1 ? rd_data_s1 : 8'h00;
	assign look.is_release = is_release_s1;

endmodule

`default_nettype wire

@@ hdl/kstr_update.sv @@
// ----------------------------------------------------------------------------
// kstr_update
// Next-state logic of the key list and modifier mask for one translated event,
// with the status code of the event.
// ----------------------------------------------------------------------------
`default_nettype none

module kstr_update #(
	parameter int KEY_SLOTS = kstr_pkg::KEY_SLOTS_DEF
) (
	input  wire logic                                 is_key,
	input  wire kstr_pkg::lookup_t                    look,
	input  wire kstr_pkg::usage_t [KEY_SLOTS-1:0]     slots,
	input  wire logic [7:0]                           mask,
	output kstr_pkg::usage_t [KEY_SLOTS-1:0]          slots_next,
	output logic [7:0]                                mask_next,
	output kstr_pkg::status_t                         status
);

	logic [KEY_SLOTS-1:0]                hit;
	logic [KEY_SLOTS-1:0]                after_hit;
	logic [KEY_SLOTS-1:0]                first_empty;
	kstr_pkg::usage_t [KEY_SLOTS-1:0]    shifted;
	logic                                seen_hit;
	logic                                seen_empty;
	logic                                is_mod;

	always_comb begin
		slots_next = slots;
		mask_next  = mask;
		status     = kstr_pkg::ST_OK;

		// Everything from the first match on moves down one slot on a release.
		seen_hit   = 1'b0;
		seen_empty = 1'b0;
		for (int k = 0; k < KEY_SLOTS; k++) begin
			hit[k]         = (slots[k] == look.code);
			seen_hit       = seen_hit | hit[k];
			after_hit[k]   = seen_hit;
			first_empty[k] = (slots[k] == 8'h00) && !seen_empty;
			seen_empty     = seen_empty | (slots[k] == 8'h00);
		end

		shifted = '0;
		for (int k = 0; k < KEY_SLOTS - 1; k++) begin
			shifted[k] = slots[k+1];
		end

		is_mod = (look.code[7:3] == kstr_pkg::MOD_PREFIX);

		if (is_key) begin
			if (look.code == 8'h00) begin
				status = kstr_pkg::ST_IGNORED;
			end else if (is_mod) begin
				mask_next[look.code[2:0]] = !look.is_release;
			end else if (look.is_release) begin
				if (!seen_hit) begin
					status = kstr_pkg::ST_NOT_LISTED;
				end else begin
					for (int k = 0; k < KEY_SLOTS; k++) begin
						if (after_hit[k]) begin
							slots_next[k] = shifted[k];
						end
					end
				end
			end else if (seen_hit) begin
				status = kstr_pkg::ST_DUPLICATE;
			end else if (!seen_empty) begin
				status = kstr_pkg::ST_FULL;
			end else begin
				for (int k = 0; k < KEY_SLOTS; k++) begin
					if (first_empty[k]) begin
						slots_next[k] = look.code;
					end
				end
			end
		end
	end

endmodule

`default_nettype wire

@@ hdl/keyboard_six_key_report_tracker.sv @@
// ----------------------------------------------------------------------------
// keyboard_six_key_report_tracker
// Keeps a boot-keyboard style report (modifier mask plus pressed-key list)
// from raw scan events translated through a loadable usage-code table.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake               Beat
// evt       in         evt_valid / evt_ready   kstr_pkg::evt_t (event or table write)
// rpt       out        rpt_valid / rpt_ready   kstr_pkg::rpt_t (report after the item)
//
// For every beat from acceptance to a report, the translation memory read is
// registered in the first stage, and the list and mask update is resolved in
// the second, landing in the report register.
// One beat is accepted per cycle; the stage register and the report register
// decouple the two sides, so evt_ready drops only while both are full and the
// report is stalled.
// Reset clears the key list, the modifier mask and the table's valid bits at
// once; there is no clearing pass.
//
`default_nettype none

module keyboard_six_key_report_tracker #(
	parameter int KEY_SLOTS = kstr_pkg::KEY_SLOTS_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           evt_valid,
	output logic                evt_ready,
	input  wire kstr_pkg::evt_t evt,
	output logic                rpt_valid,
	input  wire logic           rpt_ready,
	output kstr_pkg::rpt_t      rpt
);

	// Handshake and stage control.
	logic                                evt_fire;
	logic                                s1_valid_q;
	logic                                s1_adv;
	kstr_pkg::op_t                       op_s1;

	// Tracked report state.
	kstr_pkg::usage_t [KEY_SLOTS-1:0]    slots_q;
	logic [7:0]                          mask_q;

	// Update results.
	kstr_pkg::lookup_t                   look;
	kstr_pkg::usage_t [KEY_SLOTS-1:0]    slots_next;
	logic [7:0]                          mask_next;
	kstr_pkg::status_t                   status;
	kstr_pkg::usage_t [kstr_pkg::REPORT_SLOTS-1:0] rpt_slots;
	logic                                gap;

	// The stage moves on when the report register is free or being emptied.
	assign s1_adv    = s1_valid_q && (!rpt_valid || rpt_ready);
	assign evt_ready = !s1_valid_q || s1_adv;
	assign evt_fire  = evt_valid && evt_ready;

	// Table writes go into the memory as they are accepted, so an event
	// accepted in the following cycle already reads the new entry.
	kstr_table u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (evt_fire),
		.wr_en    (evt_fire && (evt.operation == kstr_pkg::OP_TABLE)),
		.wr_index (evt.table_index),
		.wr_value (evt.table_value),
		.raw_key  (evt.raw_key),
		.look     (look)
	);

	kstr_update #(
		.KEY_SLOTS (KEY_SLOTS)
	) u_update (
		.is_key     (op_s1 == kstr_pkg::OP_KEY),
		.look       (look),
		.slots      (slots_q),
		.mask       (mask_q),
		.slots_next (slots_next),
		.mask_next  (mask_next),
		.status     (status)
	);

	// Slots past the tracked count read as empty; tracked slots beyond the
	// sixth are kept but never reported.
	for (genvar r = 0; r < kstr_pkg::REPORT_SLOTS; r++) begin : g_rpt
		if (r < KEY_SLOTS) begin : g_live
			assign rpt_slots[r] = slots_next[r];
		end else begin : g_none
			assign rpt_slots[r] = 8'h00;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			op_s1      <= kstr_pkg::OP_KEY;
			slots_q    <= '0;
			mask_q     <= '0;
			rpt_valid  <= 1'b0;
		end else begin
			if (evt_ready) begin
				s1_valid_q <= evt_valid;
			end
			if (evt_fire) begin
				op_s1 <= kstr_pkg::op_t'(evt.operation);
			end
			if (s1_adv) begin
				slots_q   <= slots_next;
				mask_q    <= mask_next;
				rpt_valid <= 1'b1;
			end else if (rpt_ready) begin
				rpt_valid <= 1'b0;
			end
		end
	end

	// Report payload register.
	always_ff @(posedge clk) begin
		if (s1_adv) begin
			rpt.modifier_bits <= mask_next;
			rpt.slot_zero     <= rpt_slots[0];
			rpt.slot_one      <= rpt_slots[1];
			rpt.slot_two      <= rpt_slots[2];
			rpt.slot_three    <= rpt_slots[3];
			rpt.slot_four     <= rpt_slots[4];
			rpt.slot_five     <= rpt_slots[5];
			rpt.status        <= status;
		end
	end

	// The pressed list stays packed: an empty slot is never followed by a
	// used one, since presses fill the first hole and releases compact.
	always_comb begin
		gap = 1'b0;
		for (int k = 0; k < KEY_SLOTS - 1; k++) begin
			gap = gap | ((slots_q[k] == 8'h00) && (slots_q[k+1] != 8'h00));
		end
	end

	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n) !gap)
		else $error("pressed list has a hole");

	a_ready_low_means_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!evt_ready |-> (s1_valid_q && rpt_valid && !rpt_ready))
		else $error("input stalled without a full pipeline");

	a_stage_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && !rpt_valid) |=> rpt_valid)
		else $error("stage did not move into a free report register");

	a_mask_only_on_adv: assert property (@(posedge clk) disable iff (!arst_n)
		!s1_adv |=> $stable(mask_q))
		else $error("modifier mask changed without an item");

endmodule

`default_nettype wire
